FILE: src/timed_command_queue_core_assert.svh
// Assertion macros for the timed command queue core
`ifndef TIMED_COMMAND_QUEUE_CORE_ASSERT_SVH
`define TIMED_COMMAND_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define TCQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed command queue check failed");

// next-cycle implication
`define TCQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed command queue check failed");

`endif

FILE: src/tcq_pkg.sv
package tcq_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned NREL_W      = $clog2(MAX_RESULTS + 1);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [NREL_W-1:0] nrel_t;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_RELEASED = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] release_time;
        logic [7:0]  service_code;
        logic [7:0]  subservice_code;
        logic [15:0] cmd_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] out_time;
        logic [7:0]  out_service;
        logic [7:0]  out_subservice;
        logic [15:0] out_tag;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [31:0] entry_time;
        logic [7:0]  entry_service;
        logic [7:0]  entry_subservice;
        logic [15:0] entry_handle;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_TICK_CMP,
        ST_TICK_LAST
    } state_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic ptr_t ptr_dec(input ptr_t p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

endpackage

FILE: src/timed_command_queue_core.sv
// Timed command queue: holds up to QUEUE_DEPTH commands in a circular buffer sorted by
// release second (equal seconds keep arrival order). A request is taken when start is
// high and busy is low; epoch_we writes epoch_data, which the user must do only while
// the core is idle: the core does not enforce it. Results appear on result for exactly
// one cycle with result_valid high and must be taken then: the receiver cannot stall.
// An insert is answered accepted or rejected (full). An accepted insert moves each stored
// entry later than the new one one slot toward the tail, one entry per cycle, since one
// comparator and one memory port are shared. A tick releases every due head entry, one
// result per cycle (at most MAX_RESULTS per tick), marking the last with last_of_run.
// Each result is registered and appears in the cycle after the compare that decides it.
`include "timed_command_queue_core_assert.svh"

module timed_command_queue_core
    import tcq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    input  logic        epoch_we,
    input  logic [31:0] epoch_data,
    output logic        result_valid,
    output result_t     result
);

    entry_t  mem [QUEUE_DEPTH];
    entry_t  rd_data_reg;
    ptr_t    rd_addr;
    logic    mem_we;
    ptr_t    mem_waddr;
    entry_t  mem_wdata;

    state_t      state_reg, state_next;
    cnt_t        count_reg, count_next;
    cnt_t        remain_reg, remain_next;
    ptr_t        head_reg, head_next;
    ptr_t        tail_reg, tail_next;
    ptr_t        wpos_reg, wpos_next;
    nrel_t       nrel_reg, nrel_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [31:0] epoch_reg;
    logic [31:0] key_reg, key_next;
    entry_t      newent_reg, newent_next;
    entry_t      pend_reg, pend_next;
    result_t     result_reg, result_next;
    logic        result_valid_reg, result_valid_next;
    logic        le;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // shared comparator
    assign le = (rd_data_reg.entry_time <= key_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            nrel_reg         <= '0;
            elapsed_reg      <= '0;
            epoch_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            nrel_reg         <= nrel_next;
            elapsed_reg      <= elapsed_next;
            result_valid_reg <= result_valid_next;
            if (epoch_we)
            begin
                epoch_reg <= epoch_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        wpos_reg   <= wpos_next;
        key_reg    <= key_next;
        newent_reg <= newent_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        remain_next       = remain_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        wpos_next         = wpos_reg;
        nrel_next         = nrel_reg;
        elapsed_next      = elapsed_reg;
        key_next          = key_reg;
        newent_next       = newent_reg;
        pend_next         = pend_reg;
        result_next       = '0;
        result_valid_next = 1'b0;
        rd_addr           = head_reg;
        mem_we            = 1'b0;
        mem_waddr         = wpos_reg;
        mem_wdata         = newent_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (request.req_type == REQ_INSERT)
                    begin
                        if (count_reg == CNT_W'(QUEUE_DEPTH))
                        begin
                            result_valid_next       = 1'b1;
                            result_next.result_kind = KIND_REJECTED;
                            result_next.last_of_run = 1'b1;
                        end
                        else
                        begin
                            key_next                     = request.release_time;
                            newent_next.entry_time       = request.release_time;
                            newent_next.entry_service    = request.service_code;
                            newent_next.entry_subservice = request.subservice_code;
                            newent_next.entry_handle     = request.cmd_tag;
                            count_next  = count_reg + 1'b1;
                            tail_next   = ptr_inc(tail_reg);
                            wpos_next   = tail_reg;
                            remain_next = count_reg;
                            if (count_reg == '0)
                            begin
                                state_next = ST_INS_PUT;
                            end
                            else
                            begin
                                rd_addr    = ptr_dec(tail_reg);
                                state_next = ST_INS_CMP;
                            end
                        end
                    end
                    else
                    begin
                        key_next     = epoch_reg + elapsed_reg;
                        elapsed_next = elapsed_reg + 32'd1;
                        nrel_next    = '0;
                        if (count_reg != '0)
                        begin
                            rd_addr    = head_reg;
                            state_next = ST_TICK_CMP;
                        end
                    end
                end
            end

            ST_INS_CMP:
            begin
                mem_we = 1'b1;
                if (!le)
                begin
                    // move the later entry one slot toward the tail
                    mem_wdata   = rd_data_reg;
                    wpos_next   = ptr_dec(wpos_reg);
                    remain_next = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr = ptr_dec(ptr_dec(wpos_reg));
                    end
                end
                else
                begin
                    result_valid_next       = 1'b1;
                    result_next.result_kind = KIND_ACCEPTED;
                    result_next.last_of_run = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            ST_INS_PUT:
            begin
                mem_we                  = 1'b1;
                result_valid_next       = 1'b1;
                result_next.result_kind = KIND_ACCEPTED;
                result_next.last_of_run = 1'b1;
                state_next              = ST_IDLE;
            end

            ST_TICK_CMP:
            begin
                if (nrel_reg != '0)
                begin
                    result_valid_next          = 1'b1;
                    result_next.result_kind    = KIND_RELEASED;
                    result_next.out_time       = pend_reg.entry_time;
                    result_next.out_service    = pend_reg.entry_service;
                    result_next.out_subservice = pend_reg.entry_subservice;
                    result_next.out_tag        = pend_reg.entry_handle;
                    result_next.last_of_run    = !le;
                end
                if (le)
                begin
                    // hold the due head until the next compare decides its mark
                    pend_next  = rd_data_reg;
                    head_next  = ptr_inc(head_reg);
                    count_next = count_reg - 1'b1;
                    nrel_next  = nrel_reg + 1'b1;
                    if ((count_reg == CNT_W'(1)) || (nrel_reg == NREL_W'(MAX_RESULTS - 1)))
                    begin
                        state_next = ST_TICK_LAST;
                    end
                    else
                    begin
                        rd_addr = ptr_inc(head_reg);
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_TICK_LAST:
            begin
                result_valid_next          = 1'b1;
                result_next.result_kind    = KIND_RELEASED;
                result_next.out_time       = pend_reg.entry_time;
                result_next.out_service    = pend_reg.entry_service;
                result_next.out_subservice = pend_reg.entry_subservice;
                result_next.out_tag        = pend_reg.entry_handle;
                result_next.last_of_run    = 1'b1;
                state_next                 = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TCQ_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `TCQ_ASSERT_NXT(a_full_reject,
        start && !busy && (request.req_type == REQ_INSERT)
            && (count_reg == CNT_W'(QUEUE_DEPTH)),
        result_valid && (result.result_kind == KIND_REJECTED))
    `TCQ_ASSERT_NXT(a_empty_tick,
        start && !busy && (request.req_type == REQ_TICK) && (count_reg == '0),
        !result_valid && !busy)
    `TCQ_ASSERT_NXT(a_run_continues, result_valid && !result.last_of_run, result_valid)

endmodule
